FILE: rtl/edpp_pkg.sv
// shared types and constants for the eight-direction polyline plotter
// used by the channel interfaces, the controller, the datapath and the top level
`timescale 1ns / 1ps

package edpp_pkg;

    localparam int COORD_W = 6;   // vertex coordinate width
    localparam int CELL_W  = 4;   // emitted cell coordinate width
    localparam int GS_W    = 5;   // grid_size register width
    localparam int SIZE_W  = 7;   // effective grid size, holds up to 127

    localparam logic [GS_W-1:0] GS_RESET = 5'd16;

    // controller to datapath
    typedef struct packed {
        logic in_ready;
        logic emit;
    } edpp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic accepted;
        logic draw;
        logic out_free;
        logic cnt_zero;
    } edpp_sts_t;

endpackage

FILE: rtl/edpp_channels.sv
// valid/ready channel interfaces for vertex requests and cell requests
// depends on edpp_pkg for field widths
`timescale 1ns / 1ps

interface edpp_vertex_if;
    logic                           valid;
    logic                           ready;
    logic                           start_new;
    logic                           point_present;
    logic [edpp_pkg::COORD_W-1:0]   vertex_row;
    logic [edpp_pkg::COORD_W-1:0]   vertex_col;

    modport source (output valid, start_new, point_present, vertex_row, vertex_col,
                    input ready);
    modport sink   (input valid, start_new, point_present, vertex_row, vertex_col,
                    output ready);
endinterface

interface edpp_cell_if;
    logic                           valid;
    logic                           ready;
    logic [edpp_pkg::CELL_W-1:0]    cell_row;
    logic [edpp_pkg::CELL_W-1:0]    cell_col;
    logic                           last_cell;

    modport source (output valid, cell_row, cell_col, last_cell, input ready);
    modport sink   (input valid, cell_row, cell_col, last_cell, output ready);
endinterface

FILE: rtl/edpp_ctrl.sv
// controller: sequences vertex acceptance and one cell per cycle of segment drawing when the output register is free
// depends on edpp_pkg
`timescale 1ns / 1ps

module edpp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  edpp_pkg::edpp_sts_t sts,
    output edpp_pkg::edpp_cmd_t cmd
);
    import edpp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DRAW = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        cmd.in_ready = 1'b0;
        cmd.emit     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (sts.accepted && sts.draw)
                begin
                    state_next = ST_DRAW;
                end
            end
            ST_DRAW:
            begin
                cmd.emit = sts.out_free;
                // final cell of the segment goes out, back to taking vertices
                if (sts.out_free && sts.cnt_zero)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: rtl/edpp_dpath.sv
// datapath: path state, vertex checks, segment walker and output register
// depends on edpp_pkg and the channel interfaces
`timescale 1ns / 1ps

module edpp_dpath #(
    parameter int MAX_SIDE = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [edpp_pkg::GS_W-1:0]   cfg_data,
    edpp_vertex_if.sink                 vertex,
    edpp_cell_if.source                 cells,
    input  edpp_pkg::edpp_cmd_t         cmd,
    output edpp_pkg::edpp_sts_t         sts
);
    import edpp_pkg::*;

    localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_SIDE);

    logic [GS_W-1:0]    grid_size_reg;
    logic [COORD_W-1:0] prev_row_reg, prev_row_next;
    logic [COORD_W-1:0] prev_col_reg, prev_col_next;
    logic               have_prev_reg, have_prev_next;
    logic               stopped_reg, stopped_next;

    logic [COORD_W-1:0] walk_row_reg, walk_col_reg;
    logic [COORD_W-1:0] cnt_reg;
    logic               row_inc_reg, row_dec_reg, col_inc_reg, col_dec_reg;

    logic               out_valid_reg;
    logic [CELL_W-1:0]  out_row_reg, out_col_reg;
    logic               out_last_reg;

    logic [SIZE_W-1:0]  size_eff;
    logic               accepted;
    logic               bad_vertex;
    logic               prev_bad;
    logic signed [COORD_W:0] dr, dc;
    logic [COORD_W-1:0] adr, adc, seg_len;
    logic               aligned;
    logic               draw;

    always_comb
    begin
        priority if (grid_size_reg == '0)
            size_eff = SIZE_W'(1);
        else if ({2'b00, grid_size_reg} > MAX_SIZE)
            size_eff = MAX_SIZE;
        else
            size_eff = {2'b00, grid_size_reg};
    end

    assign accepted   = vertex.valid && cmd.in_ready;
    assign bad_vertex = !vertex.point_present
                        || ({1'b0, vertex.vertex_row} >= size_eff)
                        || ({1'b0, vertex.vertex_col} >= size_eff);
    assign prev_bad   = ({1'b0, prev_row_reg} >= size_eff)
                        || ({1'b0, prev_col_reg} >= size_eff);

    assign dr  = $signed({1'b0, vertex.vertex_row}) - $signed({1'b0, prev_row_reg});
    assign dc  = $signed({1'b0, vertex.vertex_col}) - $signed({1'b0, prev_col_reg});
    assign adr = dr[COORD_W] ? COORD_W'(-dr) : dr[COORD_W-1:0];
    assign adc = dc[COORD_W] ? COORD_W'(-dc) : dc[COORD_W-1:0];
    assign aligned = (dr == '0) || (dc == '0) || (adr == adc);
    assign seg_len = (adc > adr) ? adc : adr;

    // path state update for one accepted vertex
    always_comb
    begin
        prev_row_next  = prev_row_reg;
        prev_col_next  = prev_col_reg;
        have_prev_next = have_prev_reg;
        stopped_next   = stopped_reg;
        draw           = 1'b0;
        if (vertex.start_new || !stopped_reg)
        begin
            priority if (bad_vertex)
            begin
                stopped_next   = 1'b1;
                have_prev_next = 1'b0;
            end
            else if (vertex.start_new || !have_prev_reg)
            begin
                prev_row_next  = vertex.vertex_row;
                prev_col_next  = vertex.vertex_col;
                have_prev_next = 1'b1;
                stopped_next   = 1'b0;
            end
            else if (prev_bad || !aligned)
            begin
                stopped_next   = 1'b1;
                have_prev_next = 1'b0;
            end
            else
            begin
                prev_row_next = vertex.vertex_row;
                prev_col_next = vertex.vertex_col;
                draw          = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= GS_RESET;
            prev_row_reg  <= '0;
            prev_col_reg  <= '0;
            have_prev_reg <= 1'b0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                grid_size_reg <= cfg_data;
            end
            if (accepted)
            begin
                prev_row_reg  <= prev_row_next;
                prev_col_reg  <= prev_col_next;
                have_prev_reg <= have_prev_next;
                stopped_reg   <= stopped_next;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (cells.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // segment walker starts at the previous vertex and steps toward the new one
    always_ff @(posedge clk)
    begin
        if (accepted && draw)
        begin
            walk_row_reg <= prev_row_reg;
            walk_col_reg <= prev_col_reg;
            cnt_reg      <= seg_len;
            row_inc_reg  <= !dr[COORD_W] && (dr != '0);
            row_dec_reg  <= dr[COORD_W];
            col_inc_reg  <= !dc[COORD_W] && (dc != '0);
            col_dec_reg  <= dc[COORD_W];
        end
        else if (cmd.emit)
        begin
            walk_row_reg <= row_inc_reg ? walk_row_reg + 1'b1
                          : (row_dec_reg ? walk_row_reg - 1'b1 : walk_row_reg);
            walk_col_reg <= col_inc_reg ? walk_col_reg + 1'b1
                          : (col_dec_reg ? walk_col_reg - 1'b1 : walk_col_reg);
            cnt_reg      <= cnt_reg - 1'b1;
        end
        if (cmd.emit)
        begin
            out_row_reg  <= walk_row_reg[CELL_W-1:0];
            out_col_reg  <= walk_col_reg[CELL_W-1:0];
            out_last_reg <= (cnt_reg == '0);
        end
    end

    assign vertex.ready    = cmd.in_ready;
    assign cells.valid     = out_valid_reg;
    assign cells.cell_row  = out_row_reg;
    assign cells.cell_col  = out_col_reg;
    assign cells.last_cell = out_last_reg;

    assign sts.accepted = accepted;
    assign sts.draw     = draw;
    assign sts.out_free = !out_valid_reg || cells.ready;
    assign sts.cnt_zero = (cnt_reg == '0);

endmodule

FILE: rtl/eight_direction_polyline_plotter_unit.sv
// top level of the eight-direction polyline plotter
// depends on edpp_pkg, the channel interfaces, edpp_ctrl and edpp_dpath
`timescale 1ns / 1ps

// Usage:
// vertex channel (sink): one request per path vertex with start_new, point_present,
// vertex_row and vertex_col. The first vertex of a path is only stored.
// cells channel (source): for each later vertex, one request per grid cell from the
// previous vertex to this one, both ends included; last_cell marks the final one.
// cfg_write/cfg_data write grid_size; write it only while the block is idle.
// While a segment is drawn, vertex.ready stays low and the walker puts one
// cell a cycle into the output register whenever that register is free or being
// emptied; vertices that draw nothing leave vertex.ready high. A segment's first
// cell is loaded after the controller has entered its draw state.
// The output register lets the next vertex be taken while the last cell waits.
// With it full and cells.ready low the walker holds; no cell is lost or repeated.
// Reset: grid_size returns to 16, no path is held, the output register empties.
module eight_direction_polyline_plotter_unit #(
    parameter int MAX_SIDE = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_write,
    input  logic [edpp_pkg::GS_W-1:0]   cfg_data,
    edpp_vertex_if.sink                 vertex,
    edpp_cell_if.source                 cells
);
    import edpp_pkg::*;

    edpp_cmd_t cmd;
    edpp_sts_t sts;

    edpp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    edpp_dpath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .vertex    (vertex),
        .cells     (cells),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

FILE: tb/sv/tb_eight_direction_polyline_plotter_unit.sv
// self-checking bench for eight_direction_polyline_plotter_unit: vertex requests in,
// cell requests checked against an in-bench segment tracer; directed table then random paths
// depends on edpp_pkg, the channel interfaces in edpp_channels.sv and the top level rtl
`timescale 1ns / 1ps

module tb_eight_direction_polyline_plotter_unit;

    import edpp_pkg::*;

    localparam int MAX_SIDE    = 16;
    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE      = 24;
    localparam int PLAN_LEN    = 28;
    localparam int PHASE_ITEMS = 45;

    typedef enum logic [1:0] {
        STEP_VERTEX,
        STEP_CHECKED,
        STEP_GRID
    } step_kind_e;

    typedef struct packed {
        step_kind_e          kind;
        logic [GS_W-1:0]     grid;
        logic                start;
        logic                present;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  col;
        logic [1:0]          n_cells;
        logic [CELL_W-1:0]   cell_r;
        logic [CELL_W-1:0]   cell_c;
    } plan_step_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_r;
        logic [CELL_W-1:0] cell_c;
        logic              last_cell;
    } cell_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_write;
    logic [GS_W-1:0]  cfg_data;

    edpp_vertex_if vtx_ch();
    edpp_cell_if   cell_ch();

    eight_direction_polyline_plotter_unit #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .vertex    (vtx_ch),
        .cells     (cell_ch)
    );

    // tracer state
    logic [GS_W-1:0]   grid_cfg    = GS_RESET;
    logic [CELL_W-1:0] path_r      = '0;
    logic [CELL_W-1:0] path_c      = '0;
    logic              path_held   = 1'b0;
    logic              path_halted = 1'b0;
    cell_t             cells_due[$];

    // side-band of the vertex request: hand-typed expectation for table rows
    logic              vtx_typed;
    logic [1:0]        vtx_typed_n;
    logic [CELL_W-1:0] vtx_typed_r;
    logic [CELL_W-1:0] vtx_typed_c;

    plan_step_t  opening_plan [0:PLAN_LEN-1];
    logic [GS_W-1:0] phase_grid [0:8];

    int mismatches  = 0;
    int idle_cycles = 0;
    int hold_cnt    = 0;
    bit gaps_on     = 1'b1;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int eff_side(logic [GS_W-1:0] g);
        if (g == 0)
            return 1;
        if (g > MAX_SIDE)
            return MAX_SIDE;
        return int'(g);
    endfunction

    function automatic void flag_error(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR @%0t: %s", $realtime, msg);
    endfunction

    // cells from the held vertex to the new one, both ends included
    function automatic void trace_segment(logic st, logic pres,
                                          logic [COORD_W-1:0] r, logic [COORD_W-1:0] c);
        int    side;
        int    dr;
        int    dc;
        int    sr;
        int    sc;
        int    span;
        int    k;
        int    wr;
        int    wc;
        cell_t step;
        side = eff_side(grid_cfg);
        if (st)
        begin
            path_halted = 1'b0;
            path_held   = 1'b0;
        end
        else if (path_halted)
            return;
        if (!pres || r >= side || c >= side)
        begin
            path_halted = 1'b1;
            path_held   = 1'b0;
            return;
        end
        if (!path_held)
        begin
            path_r    = r[CELL_W-1:0];
            path_c    = c[CELL_W-1:0];
            path_held = 1'b1;
            return;
        end
        // grid may have shrunk under the held vertex
        if (path_r >= side || path_c >= side)
        begin
            path_halted = 1'b1;
            path_held   = 1'b0;
            return;
        end
        dr = int'(r) - int'(path_r);
        dc = int'(c) - int'(path_c);
        if (dr != 0 && dc != 0 && dr != dc && dr != -dc)
        begin
            path_halted = 1'b1;
            path_held   = 1'b0;
            return;
        end
        sr   = (dr > 0) ? 1 : ((dr < 0) ? -1 : 0);
        sc   = (dc > 0) ? 1 : ((dc < 0) ? -1 : 0);
        span = (dr < 0) ? -dr : dr;
        if (((dc < 0) ? -dc : dc) > span)
            span = (dc < 0) ? -dc : dc;
        wr = int'(path_r);
        wc = int'(path_c);
        for (k = 0; k <= span; k++)
        begin
            step.cell_r    = wr[CELL_W-1:0];
            step.cell_c    = wc[CELL_W-1:0];
            step.last_cell = (k == span);
            cells_due.push_back(step);
            wr += sr;
            wc += sc;
        end
        path_r = r[CELL_W-1:0];
        path_c = c[CELL_W-1:0];
    endfunction

    // cell checker, vertex tracer and watchdog
    always @(posedge clk)
    begin
        cell_t seen;
        cell_t want;
        int    mark;
        if (rst_n)
        begin
            if (cell_ch.valid && cell_ch.ready)
            begin
                seen.cell_r    = cell_ch.cell_row;
                seen.cell_c    = cell_ch.cell_col;
                seen.last_cell = cell_ch.last_cell;
                if (cells_due.size() == 0)
                    flag_error($sformatf("unexpected cell r=%0d c=%0d last=%0d",
                                         seen.cell_r, seen.cell_c, seen.last_cell));
                else
                begin
                    want = cells_due.pop_front();
                    if (seen.cell_r !== want.cell_r || seen.cell_c !== want.cell_c ||
                        seen.last_cell !== want.last_cell)
                        flag_error($sformatf({"cell exp r=%0d c=%0d last=%0d",
                                              " got r=%0d c=%0d last=%0d"},
                                             want.cell_r, want.cell_c, want.last_cell,
                                             seen.cell_r, seen.cell_c, seen.last_cell));
                end
            end
            if (vtx_ch.valid && vtx_ch.ready)
            begin
                mark = cells_due.size();
                trace_segment(vtx_ch.start_new, vtx_ch.point_present,
                              vtx_ch.vertex_row, vtx_ch.vertex_col);
                if (vtx_typed)
                begin
                    while (cells_due.size() > mark)
                        void'(cells_due.pop_back());
                    if (vtx_typed_n != 0)
                        cells_due.push_back('{vtx_typed_r, vtx_typed_c, 1'b1});
                end
            end
            if ((cell_ch.valid && cell_ch.ready) || (vtx_ch.valid && vtx_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no request accepted for %0d cycles", STALL_LIMIT);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // cell sink back-pressure in bursts
    always @(posedge clk)
    begin
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            cell_ch.ready <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            hold_cnt = $urandom_range(1, 14) - 1;
            cell_ch.ready <= 1'b0;
        end
        else
            cell_ch.ready <= 1'b1;
    end

    task automatic send_vertex(logic st, logic pres, logic [COORD_W-1:0] r,
                               logic [COORD_W-1:0] c, logic chk, logic [1:0] n,
                               logic [CELL_W-1:0] er, logic [CELL_W-1:0] ec);
        int pause;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            pause = $urandom_range(1, 14);
            vtx_ch.valid <= 1'b0;
            repeat (pause) @(posedge clk);
        end
        vtx_ch.valid         <= 1'b1;
        vtx_ch.start_new     <= st;
        vtx_ch.point_present <= pres;
        vtx_ch.vertex_row    <= r;
        vtx_ch.vertex_col    <= c;
        vtx_typed            <= chk;
        vtx_typed_n          <= n;
        vtx_typed_r          <= er;
        vtx_typed_c          <= ec;
        // ready is settled by the falling edge
        do
            @(negedge clk);
        while (!vtx_ch.ready);
        @(posedge clk);
    endtask

    task automatic set_grid(logic [GS_W-1:0] gsz);
        vtx_ch.valid <= 1'b0;
        // let the tracer queue the segment of the last accepted vertex
        @(negedge clk);
        while (cells_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= gsz;
        @(posedge clk);
        cfg_write <= 1'b0;
        grid_cfg = gsz;
    endtask

    // mostly well-formed paths inside the grid, with missing, out-of-grid and junk vertices
    task automatic run_phase(logic [GS_W-1:0] gsz, int n_items);
        int   side;
        int   roll;
        int   sr;
        int   sc;
        int   reach;
        int   span;
        int   cur_r;
        int   cur_c;
        int   i;
        bit   fresh;
        logic [COORD_W-1:0] nr;
        logic [COORD_W-1:0] nc;
        set_grid(gsz);
        side  = eff_side(gsz);
        fresh = 1'b1;
        cur_r = 0;
        cur_c = 0;
        for (i = 0; i < n_items; i++)
        begin
            roll = $urandom_range(0, 99);
            if (fresh || roll < 8)
            begin
                cur_r = $urandom_range(0, side - 1);
                cur_c = $urandom_range(0, side - 1);
                send_vertex(1'b1, 1'b1, 6'(cur_r), 6'(cur_c), 1'b0, 2'd0, 4'd0, 4'd0);
                fresh = 1'b0;
            end
            else if (roll < 80)
            begin
                sr    = int'($urandom_range(0, 2)) - 1;
                sc    = int'($urandom_range(0, 2)) - 1;
                reach = side - 1;
                if (sr > 0 && side - 1 - cur_r < reach)
                    reach = side - 1 - cur_r;
                if (sr < 0 && cur_r < reach)
                    reach = cur_r;
                if (sc > 0 && side - 1 - cur_c < reach)
                    reach = side - 1 - cur_c;
                if (sc < 0 && cur_c < reach)
                    reach = cur_c;
                if (sr == 0 && sc == 0)
                    reach = 0;
                span  = $urandom_range(0, reach);
                cur_r = cur_r + sr * span;
                cur_c = cur_c + sc * span;
                send_vertex(1'b0, 1'b1, 6'(cur_r), 6'(cur_c), 1'b0, 2'd0, 4'd0, 4'd0);
            end
            else if (roll < 86)
            begin
                send_vertex(1'($urandom_range(0, 1)), 1'b0, 6'($urandom_range(0, 63)),
                            6'($urandom_range(0, 63)), 1'b0, 2'd0, 4'd0, 4'd0);
                fresh = 1'b1;
            end
            else if (roll < 92)
            begin
                if ($urandom_range(0, 1))
                begin
                    nr = 6'($urandom_range(side, 63));
                    nc = 6'($urandom_range(0, 63));
                end
                else
                begin
                    nr = 6'($urandom_range(0, 63));
                    nc = 6'($urandom_range(side, 63));
                end
                send_vertex(1'($urandom_range(0, 1)), 1'b1, nr, nc, 1'b0, 2'd0, 4'd0, 4'd0);
                fresh = 1'b1;
            end
            else
            begin
                // in-grid jumps are often unaligned; anything goes otherwise
                if ($urandom_range(0, 1))
                begin
                    nr = 6'($urandom_range(0, side - 1));
                    nc = 6'($urandom_range(0, side - 1));
                    send_vertex(1'b0, 1'b1, nr, nc, 1'b0, 2'd0, 4'd0, 4'd0);
                end
                else
                    send_vertex(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                                1'b0, 2'd0, 4'd0, 4'd0);
                fresh = 1'b1;
            end
        end
    endtask

    initial
    begin
        int         i;
        plan_step_t s;
        rst_n                = 1'b0;
        cfg_write            = 1'b0;
        cfg_data             = '0;
        vtx_ch.valid         = 1'b0;
        vtx_ch.start_new     = 1'b0;
        vtx_ch.point_present = 1'b0;
        vtx_ch.vertex_row    = '0;
        vtx_ch.vertex_col    = '0;
        vtx_typed            = 1'b0;
        vtx_typed_n          = '0;
        vtx_typed_r          = '0;
        vtx_typed_c          = '0;
        cell_ch.ready        = 1'b0;

        opening_plan = '{
            // no path begun: first vertex just held, then repeated vertex
            '{STEP_CHECKED, 5'd0,  1'b0, 1'b1, 6'd3,  6'd3,  2'd0, 4'd0,  4'd0},
            '{STEP_CHECKED, 5'd0,  1'b0, 1'b1, 6'd3,  6'd3,  2'd1, 4'd3,  4'd3},
            '{STEP_VERTEX,  5'd0,  1'b0, 1'b1, 6'd3,  6'd0,  2'd0, 4'd0,  4'd0},
            '{STEP_VERTEX,  5'd0,  1'b0, 1'b1, 6'd15, 6'd0,  2'd0, 4'd0,  4'd0},
            '{STEP_VERTEX,  5'd0,  1'b0, 1'b1, 6'd0,  6'd15, 2'd0, 4'd0,  4'd0},
            '{STEP_VERTEX,  5'd0,  1'b0, 1'b1, 6'd15, 6'd15, 2'd0, 4'd0,  4'd0},
            '{STEP_VERTEX,  5'd0,  1'b0, 1'b1, 6'd0,  6'd0,  2'd0, 4'd0,  4'd0},
            // unaligned, then stopped path ignores a plain vertex; restarts, missing and out-of-grid vertices
            '{STEP_CHECKED, 5'd0,  1'b0, 1'b1, 6'd5,  6'd6,  2'd0, 4'd0,  4'd0},
            '{STEP_CHECKED, 5'd0,  1'b0, 1'b1, 6'd5,  6'd5,  2'd0, 4'd0,  4'd0},
            '{STEP_CHECKED, 5'd0,  1'b1, 1'b1, 6'd15, 6'd15, 2'd0, 4'd0,  4'd0},
            '{STEP_CHECKED, 5'd0,  1'b0, 1'b0, 6'd42, 6'd21, 2'd0, 4'd0,  4'd0},
            '{STEP_CHECKED, 5'd0,  1'b1, 1'b1, 6'd2,  6'd2,  2'd0, 4'd0,  4'd0},
            '{STEP_CHECKED, 5'd0,  1'b0, 1'b1, 6'd63, 6'd2,  2'd0, 4'd0,  4'd0},
            '{STEP_CHECKED, 5'd0,  1'b1, 1'b1, 6'd0,  6'd0,  2'd0, 4'd0,  4'd0},
            '{STEP_CHECKED, 5'd0,  1'b0, 1'b1, 6'd0,  6'd63, 2'd0, 4'd0,  4'd0},
            '{STEP_CHECKED, 5'd0,  1'b1, 1'b0, 6'd63, 6'd63, 2'd0, 4'd0,  4'd0},
            '{STEP_CHECKED, 5'd0,  1'b1, 1'b1, 6'd12, 6'd12, 2'd0, 4'd0,  4'd0},
            // shrink the grid under the held vertex
            '{STEP_GRID,    5'd3,  1'b0, 1'b0, 6'd0,  6'd0,  2'd0, 4'd0,  4'd0},
            '{STEP_CHECKED, 5'd0,  1'b0, 1'b1, 6'd1,  6'd1,  2'd0, 4'd0,  4'd0},
            '{STEP_CHECKED, 5'd0,  1'b1, 1'b1, 6'd0,  6'd2,  2'd0, 4'd0,  4'd0},
            '{STEP_VERTEX,  5'd0,  1'b0, 1'b1, 6'd2,  6'd0,  2'd0, 4'd0,  4'd0},
            // zero grid acts as a single cell
            '{STEP_GRID,    5'd0,  1'b0, 1'b0, 6'd0,  6'd0,  2'd0, 4'd0,  4'd0},
            '{STEP_CHECKED, 5'd0,  1'b1, 1'b1, 6'd0,  6'd0,  2'd0, 4'd0,  4'd0},
            '{STEP_CHECKED, 5'd0,  1'b0, 1'b1, 6'd0,  6'd0,  2'd1, 4'd0,  4'd0},
            '{STEP_CHECKED, 5'd0,  1'b0, 1'b1, 6'd1,  6'd0,  2'd0, 4'd0,  4'd0},
            // oversize grid clamps to full side
            '{STEP_GRID,    5'd31, 1'b0, 1'b0, 6'd0,  6'd0,  2'd0, 4'd0,  4'd0},
            '{STEP_CHECKED, 5'd0,  1'b1, 1'b1, 6'd15, 6'd0,  2'd0, 4'd0,  4'd0},
            '{STEP_VERTEX,  5'd0,  1'b0, 1'b1, 6'd15, 6'd15, 2'd0, 4'd0,  4'd0}
        };
        phase_grid = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd9, 5'd17, 5'd2, 5'd16, 5'd16};
        phase_grid[7] = 5'($urandom_range(1, 31));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < PLAN_LEN; i++)
        begin
            s = opening_plan[i];
            if (s.kind == STEP_GRID)
                set_grid(s.grid);
            else
                send_vertex(s.start, s.present, s.row, s.col, s.kind == STEP_CHECKED,
                            s.n_cells, s.cell_r, s.cell_c);
        end

        for (i = 0; i < 9; i++)
        begin
            if (i == 8)
                gaps_on = 1'b0;
            run_phase(phase_grid[i], PHASE_ITEMS);
        end

        vtx_ch.valid <= 1'b0;
        @(negedge clk);
        while (cells_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (cells_due.size() != 0)
            flag_error($sformatf("%0d cells never emitted", cells_due.size()));
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
rtl/edpp_pkg.sv
rtl/edpp_channels.sv
rtl/edpp_ctrl.sv
rtl/edpp_dpath.sv
rtl/eight_direction_polyline_plotter_unit.sv
tb/sv/tb_eight_direction_polyline_plotter_unit.sv
